>>> rtl/blc_pkg.sv
package blc_pkg;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned BTN_W    = 2;
  localparam int unsigned MODE_W   = 4;
  localparam int unsigned SCENE_W  = 3;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_TIME     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCK_DEBOUNCE = 1'd1;

  localparam logic [CFG_W-1:0] TURN_TIME_RST     = 16'd3000;
  localparam logic [CFG_W-1:0] LOCK_DEBOUNCE_RST = 16'd500;

  // Button sample codes
  localparam logic [BTN_W-1:0] BTN_REL   = 2'd0;
  localparam logic [BTN_W-1:0] BTN_SHORT = 2'd1;
  localparam logic [BTN_W-1:0] BTN_LONG  = 2'd2;

  // Rear scene codes; the front channel uses only bit 0 (off/on)
  localparam logic [SCENE_W-1:0] SC_OFF   = 3'd0;
  localparam logic [SCENE_W-1:0] SC_ON    = 3'd1;
  localparam logic [SCENE_W-1:0] SC_BLINK = 3'd2;
  localparam logic [SCENE_W-1:0] SC_LIT   = 3'd3;
  localparam logic [SCENE_W-1:0] SC_DARK  = 3'd4;

  // Mode codes as reported on the result channel
  localparam logic [MODE_W-1:0] MC_UNDEF    = 4'd0;
  localparam logic [MODE_W-1:0] MC_OFF      = 4'd1;
  localparam logic [MODE_W-1:0] MC_OFF_LOCK = 4'd2;
  localparam logic [MODE_W-1:0] MC_ON_LOCK  = 4'd3;
  localparam logic [MODE_W-1:0] MC_ON       = 4'd4;
  localparam logic [MODE_W-1:0] MC_TURN_L   = 4'd5;
  localparam logic [MODE_W-1:0] MC_TURN_R   = 4'd6;
  localparam logic [MODE_W-1:0] MC_LIT_L    = 4'd7;
  localparam logic [MODE_W-1:0] MC_LIT_R    = 4'd8;

  typedef enum logic [8:0] {
    MODE_UNDEF    = 9'b000000001,
    MODE_OFF      = 9'b000000010,
    MODE_OFF_LOCK = 9'b000000100,
    MODE_ON_LOCK  = 9'b000001000,
    MODE_ON       = 9'b000010000,
    MODE_TURN_L   = 9'b000100000,
    MODE_TURN_R   = 9'b001000000,
    MODE_LIT_L    = 9'b010000000,
    MODE_LIT_R    = 9'b100000000
  } mode_t;

  typedef struct packed {
    mode_t                mode;
    logic [TIME_W-1:0]    turn_start;
    logic [TIME_W-1:0]    lock_start;
    logic                 front_sel;
    logic [SCENE_W-1:0]   rear_left_sel;
    logic [SCENE_W-1:0]   rear_right_sel;
  } blc_state_t;

  typedef struct packed {
    logic front;
    logic rear_left;
    logic rear_right;
  } blc_chg_t;

  function automatic logic [MODE_W-1:0] mode_code(input mode_t m);
    logic [MODE_W-1:0] c;
    case (m)
      MODE_OFF:      c = MC_OFF;
      MODE_OFF_LOCK: c = MC_OFF_LOCK;
      MODE_ON_LOCK:  c = MC_ON_LOCK;
      MODE_ON:       c = MC_ON;
      MODE_TURN_L:   c = MC_TURN_L;
      MODE_TURN_R:   c = MC_TURN_R;
      MODE_LIT_L:    c = MC_LIT_L;
      MODE_LIT_R:    c = MC_LIT_R;
      default:       c = MC_UNDEF;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/blc_if.sv
interface blc_in_if;
  import blc_pkg::*;
  logic               valid;
  logic               ready;
  logic [BTN_W-1:0]   left_button;
  logic [BTN_W-1:0]   right_button;
  logic [TIME_W-1:0]  now_ms;

  modport source(output valid, output left_button, output right_button, output now_ms,
                 input ready);
  modport sink(input valid, input left_button, input right_button, input now_ms,
               output ready);
endinterface

interface blc_out_if;
  import blc_pkg::*;
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic               front_scene;
  logic [SCENE_W-1:0] rear_left_scene;
  logic [SCENE_W-1:0] rear_right_scene;
  logic               front_changed;
  logic               rear_left_changed;
  logic               rear_right_changed;

  modport source(output valid, output mode, output front_scene, output rear_left_scene,
                 output rear_right_scene, output front_changed, output rear_left_changed,
                 output rear_right_changed, input ready);
  modport sink(input valid, input mode, input front_scene, input rear_left_scene,
               input rear_right_scene, input front_changed, input rear_left_changed,
               input rear_right_changed, output ready);
endinterface

>>> rtl/blc_step.sv
module blc_step
  import blc_pkg::*;
(
  input  blc_state_t         cur,
  input  logic [BTN_W-1:0]   left_button,
  input  logic [BTN_W-1:0]   right_button,
  input  logic [TIME_W-1:0]  now_ms,
  input  logic [CFG_W-1:0]   turn_time_ms,
  input  logic [CFG_W-1:0]   lock_debounce_ms,
  output blc_state_t         nxt,
  output blc_chg_t           chg
);

  logic              both_rel;
  logic              both_long;
  logic              left_short;
  logic              right_short;
  logic              lit;
  logic              is_left;
  logic              extend;
  logic              turn_left;
  logic              prev_lit_other;
  logic [SCENE_W-1:0] other_sc;
  logic [TIME_W-1:0] turn_age;
  logic [TIME_W-1:0] lock_age;
  logic              turn_over;
  logic              lock_over;
  mode_t             next_mode;

  assign both_rel    = (left_button == BTN_REL)   && (right_button == BTN_REL);
  assign both_long   = (left_button == BTN_LONG)  && (right_button == BTN_LONG);
  assign left_short  = (left_button == BTN_SHORT) && (right_button == BTN_REL);
  assign right_short = (left_button == BTN_REL)   && (right_button == BTN_SHORT);
  assign lit         = (cur.mode == MODE_LIT_L) || (cur.mode == MODE_LIT_R);
  assign is_left     = (cur.mode == MODE_TURN_L) || (cur.mode == MODE_LIT_L);

  // Elapsed time wraps modulo 2^32
  assign turn_age  = now_ms - cur.turn_start;
  assign lock_age  = now_ms - cur.lock_start;
  assign turn_over = turn_age > {{(TIME_W-CFG_W){1'b0}}, turn_time_ms};
  assign lock_over = lock_age > {{(TIME_W-CFG_W){1'b0}}, lock_debounce_ms};

  always_comb begin
    next_mode = cur.mode;
    extend    = 1'b0;
    nxt       = cur;
    chg       = '0;
    case (cur.mode)
      MODE_OFF_LOCK, MODE_ON_LOCK: begin
        if (both_rel && lock_over) begin
          next_mode = (cur.mode == MODE_OFF_LOCK) ? MODE_OFF : MODE_ON;
        end
      end
      MODE_OFF, MODE_ON: begin
        if (both_long) begin
          nxt.lock_start = now_ms;
          next_mode = (cur.mode == MODE_OFF) ? MODE_ON_LOCK : MODE_OFF_LOCK;
        end else if (left_short) begin
          next_mode = (cur.mode == MODE_OFF) ? MODE_TURN_L : MODE_LIT_L;
        end else if (right_short) begin
          next_mode = (cur.mode == MODE_OFF) ? MODE_TURN_R : MODE_LIT_R;
        end
      end
      MODE_TURN_L, MODE_TURN_R, MODE_LIT_L, MODE_LIT_R: begin
        if (is_left ? right_short : left_short) begin
          if (is_left) begin
            next_mode = lit ? MODE_LIT_R : MODE_TURN_R;
          end else begin
            next_mode = lit ? MODE_LIT_L : MODE_TURN_L;
          end
        end else if (is_left ? left_short : right_short) begin
          extend = 1'b1;
        end else if (turn_over) begin
          next_mode = lit ? MODE_ON : MODE_OFF;
        end
      end
      default: begin
        next_mode = MODE_OFF;
      end
    endcase

    // Scene selection on the far rear side depends on the mode before the step
    turn_left = (next_mode == MODE_TURN_L) || (next_mode == MODE_LIT_L);
    prev_lit_other = (cur.mode == MODE_ON) ||
                     (turn_left ? (cur.mode == MODE_LIT_R) : (cur.mode == MODE_LIT_L));
    other_sc = prev_lit_other ? SC_LIT : SC_DARK;

    if ((next_mode != cur.mode) || extend) begin
      case (next_mode)
        MODE_OFF, MODE_OFF_LOCK: begin
          nxt.front_sel      = SC_OFF[0];
          nxt.rear_left_sel  = SC_OFF;
          nxt.rear_right_sel = SC_OFF;
          chg                = '1;
        end
        MODE_ON, MODE_ON_LOCK: begin
          nxt.front_sel      = SC_ON[0];
          nxt.rear_left_sel  = SC_ON;
          nxt.rear_right_sel = SC_ON;
          chg                = '1;
        end
        MODE_TURN_L, MODE_TURN_R, MODE_LIT_L, MODE_LIT_R: begin
          nxt.turn_start = now_ms;
          if (!extend) begin
            nxt.rear_left_sel  = turn_left ? SC_BLINK : other_sc;
            nxt.rear_right_sel = turn_left ? other_sc : SC_BLINK;
            chg.rear_left      = 1'b1;
            chg.rear_right     = 1'b1;
          end
        end
        default: begin
        end
      endcase
      nxt.mode = next_mode;
    end
  end

endmodule

>>> rtl/bike_light_turn_signal_controller.sv
// Bike light and turn signal controller.
//
// in_if  : button samples (left_button, right_button, now_ms) under valid/ready.
// out_if : one result per sample: the mode after the step, the scene selected on
//          the front, rear left and rear right channels, and a changed pulse for
//          each channel whose scene was reselected by that sample.
// cfg_*  : write port for turn_time_ms (index 0) and lock_debounce_ms (index 1);
//          write only while no transaction is in flight.
//
// Timing: a sample is captured in an input register, the mode update runs as one
// short combinational step from that register into the controller state and the
// result register. A result passes through the input register and then the result
// register (two register stages), and one transaction is taken every cycle while
// out_if.ready stays high; the state feedback closes within that single step, so
// back-to-back samples see each other's updates.
//
// Reset (rst_n low, synchronous) empties both stages, puts the controller in the
// undefined mode with all scenes off and loads the register defaults 3000/500.
// When the receiver stalls, the result register holds; the input stage still
// takes one more sample and then drops in_if.ready until out_if.ready returns.
module bike_light_turn_signal_controller
  import blc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  blc_in_if.sink                in_if,
  blc_out_if.source             out_if,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  // Input stage
  logic              s1_v_r, s1_v_nxt;
  logic [BTN_W-1:0]  s1_left_r;
  logic [BTN_W-1:0]  s1_right_r;
  logic [TIME_W-1:0] s1_now_r;

  // Result stage
  logic               out_v_r, out_v_nxt;
  logic [MODE_W-1:0]  out_mode_r;
  logic               out_front_r;
  logic [SCENE_W-1:0] out_rl_r;
  logic [SCENE_W-1:0] out_rr_r;
  blc_chg_t           out_chg_r;

  // Controller state and configuration
  blc_state_t        st_r, st_nxt;
  blc_chg_t          chg;
  logic [CFG_W-1:0]  turn_time_r;
  logic [CFG_W-1:0]  lock_debounce_r;

  logic in_acc;
  logic advance;
  logic fire;

  // Advance when the result register is empty or being drained
  assign advance     = !out_v_r || out_if.ready;
  assign fire        = s1_v_r && advance;
  assign in_if.ready = !s1_v_r || advance;
  assign in_acc      = in_if.valid && in_if.ready;

  assign s1_v_nxt  = in_acc ? 1'b1 : (fire ? 1'b0 : s1_v_r);
  assign out_v_nxt = fire ? 1'b1 : (out_if.ready ? 1'b0 : out_v_r);

  blc_step u_step (
    .cur              (st_r),
    .left_button      (s1_left_r),
    .right_button     (s1_right_r),
    .now_ms           (s1_now_r),
    .turn_time_ms     (turn_time_r),
    .lock_debounce_ms (lock_debounce_r),
    .nxt              (st_nxt),
    .chg              (chg)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Payload of the input stage: load on every accepted transaction
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_left_r  <= in_if.left_button;
      s1_right_r <= in_if.right_button;
      s1_now_r   <= in_if.now_ms;
    end
  end

  // Controller state advances together with the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode           <= MODE_UNDEF;
      st_r.turn_start     <= '0;
      st_r.lock_start     <= '0;
      st_r.front_sel      <= SC_OFF[0];
      st_r.rear_left_sel  <= SC_OFF;
      st_r.rear_right_sel <= SC_OFF;
    end else if (fire) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_mode_r  <= mode_code(st_nxt.mode);
      out_front_r <= st_nxt.front_sel;
      out_rl_r    <= st_nxt.rear_left_sel;
      out_rr_r    <= st_nxt.rear_right_sel;
      out_chg_r   <= chg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turn_time_r     <= TURN_TIME_RST;
      lock_debounce_r <= LOCK_DEBOUNCE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TURN_TIME:     turn_time_r     <= cfg_wdata;
        CFG_LOCK_DEBOUNCE: lock_debounce_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign out_if.valid              = out_v_r;
  assign out_if.mode               = out_mode_r;
  assign out_if.front_scene        = out_front_r;
  assign out_if.rear_left_scene    = out_rl_r;
  assign out_if.rear_right_scene   = out_rr_r;
  assign out_if.front_changed      = out_chg_r.front;
  assign out_if.rear_left_changed  = out_chg_r.rear_left;
  assign out_if.rear_right_changed = out_chg_r.rear_right;

endmodule
